// ===== hdl/pgr_pkg.sv =====
// Shared constants and types of the proportional glyph rasterizer.
`default_nettype none

package pgr_pkg;

  // Font storage sizes.
  localparam int MAX_GLYPHS   = 128;
  localparam int BITMAP_BYTES = 2048;
  localparam int MAX_WIDTH    = 8;
  localparam int MAX_HEIGHT   = 16;
  localparam int ROW_LIMIT    = (MAX_HEIGHT < 16) ? MAX_HEIGHT : 16;

  localparam int GLYPH_AW = $clog2(MAX_GLYPHS);
  localparam int BMP_AW   = $clog2(BITMAP_BYTES);
  // Bit address: offset*8 + column*height + row - lift, wide enough to wrap the byte address.
  localparam int BIT_W    = (BMP_AW + 3 > 15) ? BMP_AW + 3 : 15;

  // Input item modes.
  localparam logic [1:0] MODE_DESC = 2'd0;
  localparam logic [1:0] MODE_BMAP = 2'd1;
  localparam logic [1:0] MODE_DRAW = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FIRST_CODE   = 3'd0;
  localparam logic [2:0] REG_GLYPH_COUNT  = 3'd1;
  localparam logic [2:0] REG_MISSING_CODE = 3'd2;
  localparam logic [2:0] REG_FONT_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_INK_COLOR    = 3'd4;
  localparam logic [2:0] REG_PAPER_COLOR  = 3'd5;

  typedef struct packed {
    logic [3:0]  width;
    logic [4:0]  lift;
    logic [4:0]  height;
    logic [10:0] offset;
  } desc_t;

endpackage

`default_nettype wire

// ===== hdl/proportional_glyph_rasterizer_top.sv =====
// Top level of the proportional glyph rasterizer: pipeline, font memories, register port.
`default_nettype none
// A draw item passes the input register, row generator, bitmap byte register and output
// register before its first pixel is offered. A draw emits min(font_height,16) pixels,
// one pixel per cycle unless the output stalls; writes and font_height 0 draws emit none.
// The row generator stage sets the rate, feeding one bitmap memory read per cycle.
// Reset clears all valid bits and the row counter and loads the register reset values;
// the descriptor and bitmap memories are not cleared and read undefined until written.

module proportional_glyph_rasterizer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // input item channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  char_code,
  input  wire logic [3:0]  column,
  input  wire logic [10:0] table_address,
  input  wire logic [3:0]  desc_width,
  input  wire logic [4:0]  desc_lift,
  input  wire logic [4:0]  desc_height,
  input  wire logic [10:0] desc_offset,
  input  wire logic [7:0]  data_byte,
  // result item channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      pixel_color,
  output logic [3:0]       row,
  output logic [3:0]       char_width,
  output logic             last_pixel,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]  first_code;
  logic [7:0]  glyph_count;
  logic [7:0]  missing_code;
  logic [4:0]  font_height;
  logic [15:0] ink_color;
  logic [15:0] paper_color;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_code   <= 8'd32;
      glyph_count  <= 8'd0;
      missing_code <= 8'd32;
      font_height  <= 5'd16;
      ink_color    <= 16'hFFFF;
      paper_color  <= 16'h0000;
    end else if (cfg_write) begin
      case (paddr[4:2])
        pgr_pkg::REG_FIRST_CODE:   first_code   <= pwdata[7:0];
        pgr_pkg::REG_GLYPH_COUNT:  glyph_count  <= pwdata[7:0];
        pgr_pkg::REG_MISSING_CODE: missing_code <= pwdata[7:0];
        pgr_pkg::REG_FONT_HEIGHT:  font_height  <= pwdata[4:0];
        pgr_pkg::REG_INK_COLOR:    ink_color    <= pwdata[15:0];
        pgr_pkg::REG_PAPER_COLOR:  paper_color  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      pgr_pkg::REG_FIRST_CODE:   prdata = {24'd0, first_code};
      pgr_pkg::REG_GLYPH_COUNT:  prdata = {24'd0, glyph_count};
      pgr_pkg::REG_MISSING_CODE: prdata = {24'd0, missing_code};
      pgr_pkg::REG_FONT_HEIGHT:  prdata = {27'd0, font_height};
      pgr_pkg::REG_INK_COLOR:    prdata = {16'd0, ink_color};
      pgr_pkg::REG_PAPER_COLOR:  prdata = {16'd0, paper_color};
      default:                   prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage A: input register and font lookup
  // ---------------------------------------------------------------------------
  logic        a_valid;
  logic [1:0]  a_mode;
  logic [7:0]  a_code;
  logic [3:0]  a_column;
  logic [10:0] a_addr;
  pgr_pkg::desc_t a_desc;
  logic [7:0]  a_data;
  logic        a_ready;

  logic        b_ready;

  assign a_ready  = !a_valid || b_ready;
  assign in_stall = !a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_mode        <= mode;
      a_code        <= char_code;
      a_column      <= column;
      a_addr        <= table_address;
      a_desc.width  <= desc_width;
      a_desc.lift   <= desc_lift;
      a_desc.height <= desc_height;
      a_desc.offset <= desc_offset;
      a_data        <= data_byte;
    end
  end

  // Glyph count is capped at the table depth.
  logic [8:0]  eff_count;
  logic [7:0]  code_delta;
  logic [7:0]  absent_delta;
  logic        code_hit;
  logic        absent_hit;
  logic        a_found;
  logic [pgr_pkg::GLYPH_AW-1:0] a_index;

  always_comb begin
    eff_count = ({1'b0, glyph_count} < 9'(pgr_pkg::MAX_GLYPHS)) ?
                {1'b0, glyph_count} : 9'(pgr_pkg::MAX_GLYPHS);
    code_delta   = a_code - first_code;
    absent_delta = missing_code - first_code;
    code_hit     = (a_code >= first_code) && ({1'b0, code_delta} < eff_count);
    absent_hit   = (missing_code >= first_code) && ({1'b0, absent_delta} < eff_count);
    a_found      = code_hit || absent_hit;
    // Fall back to the absent code's glyph when the requested one is missing.
    a_index      = code_hit ? code_delta[pgr_pkg::GLYPH_AW-1:0] :
                              absent_delta[pgr_pkg::GLYPH_AW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Descriptor memory: written and read on the A to B edge, so order holds
  // ---------------------------------------------------------------------------
  pgr_pkg::desc_t desc_mem [pgr_pkg::MAX_GLYPHS];
  pgr_pkg::desc_t b_desc;

  always_ff @(posedge clk) begin
    if (a_valid && b_ready && (a_mode == pgr_pkg::MODE_DESC) &&
        (32'(a_addr) < pgr_pkg::MAX_GLYPHS)) begin
      desc_mem[a_addr[pgr_pkg::GLYPH_AW-1:0]] <= a_desc;
    end
    if (b_ready) begin
      b_desc <= desc_mem[a_index];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: row generator
  // ---------------------------------------------------------------------------
  logic        b_valid;
  logic [1:0]  b_mode;
  logic        b_found;
  logic [3:0]  b_column;
  logic [10:0] b_addr;
  logic [7:0]  b_data;
  logic [3:0]  b_row;

  logic        c_ready;

  // Descriptor writes and unused modes end at stage A.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid &&
                 ((a_mode == pgr_pkg::MODE_BMAP) || (a_mode == pgr_pkg::MODE_DRAW));
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_mode   <= a_mode;
      b_found  <= a_found;
      b_column <= a_column;
      b_addr   <= a_addr;
      b_data   <= a_data;
    end
  end

  pgr_pkg::desc_t glyph;
  logic [3:0]  b_width;
  logic [4:0]  rows;
  logic [4:0]  b_y;
  logic [5:0]  ink_top;
  logic        b_ink;
  logic        b_last;
  logic        b_draw;
  logic        b_empty;
  logic        b_emit;
  logic        b_fire;
  logic        b_done;
  logic [pgr_pkg::BIT_W-1:0] bit_addr;
  logic [pgr_pkg::BMP_AW-1:0] byte_addr;

  always_comb begin
    glyph   = b_found ? b_desc : '0;
    b_width = (glyph.width > 4'(pgr_pkg::MAX_WIDTH)) ? 4'(pgr_pkg::MAX_WIDTH) : glyph.width;
    rows    = (font_height > 5'(pgr_pkg::ROW_LIMIT)) ? 5'(pgr_pkg::ROW_LIMIT) : font_height;
    b_y     = {1'b0, b_row};
    ink_top = {1'b0, glyph.lift} + {1'b0, glyph.height};
    // Spacing column and everything beyond it are background.
    b_ink   = (b_column < b_width) && (b_y >= glyph.lift) && ({1'b0, b_y} < ink_top);
    b_last  = (b_y + 5'd1) == rows;
    bit_addr = pgr_pkg::BIT_W'({glyph.offset, 3'b000})
             + pgr_pkg::BIT_W'(b_column) * pgr_pkg::BIT_W'(glyph.height)
             + pgr_pkg::BIT_W'(b_y) - pgr_pkg::BIT_W'(glyph.lift);
    // Byte address wraps over the bitmap size.
    byte_addr = bit_addr[pgr_pkg::BMP_AW+2:3];

    b_draw  = b_mode == pgr_pkg::MODE_DRAW;
    b_empty = b_draw && (rows == 5'd0);
    b_emit  = b_valid && !b_empty;
    b_fire  = b_emit && c_ready;
    b_done  = (b_valid && b_empty) || (b_fire && (!b_draw || b_last));
    b_ready = !b_valid || b_done;
  end

  // Advance the row on every emitted pixel; wrap to zero after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_row <= 4'd0;
    end else if (b_fire && b_draw) begin
      b_row <= b_last ? 4'd0 : b_row + 4'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // Bitmap memory: written and read on the B to C edge, in item order
  // ---------------------------------------------------------------------------
  logic [7:0] bmp_mem [pgr_pkg::BITMAP_BYTES];
  logic [7:0] c_byte;

  always_ff @(posedge clk) begin
    if (b_fire && !b_draw && (32'(b_addr) < pgr_pkg::BITMAP_BYTES)) begin
      bmp_mem[b_addr[pgr_pkg::BMP_AW-1:0]] <= b_data;
    end
    if (c_ready) begin
      c_byte <= bmp_mem[byte_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: bitmap byte and pixel attributes
  // ---------------------------------------------------------------------------
  logic       c_valid;
  logic       c_ink;
  logic [2:0] c_bit;
  logic [3:0] c_row;
  logic [3:0] c_width;
  logic       c_last;
  logic       d_ready;

  assign c_ready = !c_valid || d_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_fire && b_draw;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_ink   <= b_ink;
      c_bit   <= bit_addr[2:0];
      c_row   <= b_row;
      c_width <= b_width;
      c_last  <= b_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: output register
  // ---------------------------------------------------------------------------
  assign d_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_ready) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      pixel_color <= (c_ink && c_byte[c_bit]) ? ink_color : paper_color;
      row         <= c_row;
      char_width  <= c_width;
      last_pixel  <= c_last;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_proportional_glyph_rasterizer_top.sv =====
// Self-checking testbench for the proportional glyph rasterizer: random font loads and draws.
module tb_proportional_glyph_rasterizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pgr_pkg::*;

  // Mode code that the block ignores.
  localparam logic [1:0] MODE_SKIP = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  code;
    logic [3:0]  col;
    logic [10:0] addr;
    logic [3:0]  width;
    logic [4:0]  lift;
    logic [4:0]  height;
    logic [10:0] offset;
    logic [7:0]  data;
  } glyph_item_t;

  typedef struct {
    logic [15:0] color;
    logic [3:0]  row;
    logic [3:0]  width;
    logic        last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = '0;
  logic [7:0]  char_code = '0;
  logic [3:0]  column = '0;
  logic [10:0] table_address = '0;
  logic [3:0]  desc_width = '0;
  logic [4:0]  desc_lift = '0;
  logic [4:0]  desc_height = '0;
  logic [10:0] desc_offset = '0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] pixel_color;
  logic [3:0]  row;
  logic [3:0]  char_width;
  logic        last_pixel;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  proportional_glyph_rasterizer_top i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register mirror, starting from the reset values.
  logic [7:0]  cfg_first  = 8'd32;
  logic [7:0]  cfg_count  = 8'd0;
  logic [7:0]  cfg_absent = 8'd32;
  logic [4:0]  cfg_height = 5'd16;
  logic [15:0] cfg_fg     = 16'hFFFF;
  logic [15:0] cfg_bg     = 16'h0000;

  // Font contents as the block holds them, updated at acceptance.
  desc_t       font_desc [MAX_GLYPHS];
  logic [7:0]  font_bits [BITMAP_BYTES];

  // Font contents as the stimulus has queued them; keeps draws off unwritten entries.
  desc_t       plan_desc    [MAX_GLYPHS];
  bit          plan_desc_ok [MAX_GLYPHS];
  bit          plan_byte_ok [BITMAP_BYTES];

  glyph_item_t queued_items [$];
  pixel_t      pending_pixels [$];
  int          items_owed  = 0;
  int          planned     = 0;
  int          fails       = 0;
  int          pixels_seen = 0;
  logic        calm        = 1'b0;

  // ---------------------------------------------------------------------------------------
  // Font lookup and pixel arithmetic
  // ---------------------------------------------------------------------------------------

  // Table index of a code, if the code lies inside the font.
  function automatic bit find_glyph(input logic [7:0] code, output int idx);
    logic [7:0] d;
    int         eff;
    d   = code - cfg_first;
    eff = (cfg_count > MAX_GLYPHS) ? MAX_GLYPHS : int'(cfg_count);
    idx = int'(d);
    return (code >= cfg_first) && (int'(d) < eff);
  endfunction

  // Fall back to the absent code; both missing means a blank glyph.
  function automatic bit resolve_glyph(input logic [7:0] code, output int idx);
    if (find_glyph(code, idx)) return 1'b1;
    return find_glyph(cfg_absent, idx);
  endfunction

  function automatic int glyph_cols(input desc_t g);
    return (g.width > MAX_WIDTH) ? MAX_WIDTH : int'(g.width);
  endfunction

  function automatic int row_count();
    return (cfg_height > ROW_LIMIT) ? ROW_LIMIT : int'(cfg_height);
  endfunction

  // True when the pixel comes from the bitmap; gives the byte and bit it reads.
  function automatic bit ink_bit(input desc_t g, input logic [3:0] col, input int y,
                                 output int baddr, output int bpos);
    int bitno;
    baddr = 0;
    bpos  = 0;
    if (int'(col) >= glyph_cols(g) || y < int'(g.lift) || y >= int'(g.lift) + int'(g.height))
      return 1'b0;
    bitno = int'(g.offset) * 8 + int'(col) * int'(g.height) + (y - int'(g.lift));
    baddr = (bitno >> 3) % BITMAP_BYTES;
    bpos  = bitno & 7;
    return 1'b1;
  endfunction

  // Expected pixels of one drawn column, bottom row first.
  task automatic predict_column(input logic [7:0] code, input logic [3:0] col);
    desc_t  g;
    int     idx, rows, baddr, bpos;
    pixel_t px;
    g = '0;
    if (resolve_glyph(code, idx)) g = font_desc[idx];
    rows = row_count();
    for (int y = 0; y < rows; y++) begin
      px.color = cfg_bg;
      if (ink_bit(g, col, y, baddr, bpos) && font_bits[baddr][bpos]) px.color = cfg_fg;
      px.row   = 4'(y);
      px.width = 4'(glyph_cols(g));
      px.last  = (y == rows - 1);
      pending_pixels.push_back(px);
    end
  endtask

  task automatic apply_item(input glyph_item_t r);
    case (r.mode)
      MODE_DESC: if (r.addr < MAX_GLYPHS)
        font_desc[r.addr[GLYPH_AW-1:0]] = '{r.width, r.lift, r.height, r.offset};
      MODE_BMAP: if (r.addr < BITMAP_BYTES) font_bits[r.addr] = r.data;
      MODE_DRAW: predict_column(r.code, r.col);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------------------

  // Mostly short gaps, a few long ones, none at all while calm.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Every field random; the caller overrides the ones that matter.
  function automatic glyph_item_t rand_item();
    glyph_item_t r;
    r.mode   = 2'($urandom);
    r.code   = 8'($urandom);
    r.col    = 4'($urandom);
    r.addr   = 11'($urandom);
    r.width  = 4'($urandom);
    r.lift   = 5'($urandom);
    r.height = 5'($urandom);
    r.offset = 11'($urandom);
    r.data   = 8'($urandom);
    return r;
  endfunction

  // Mostly glyphs that show ink, sometimes anything the fields hold.
  function automatic desc_t pick_desc();
    desc_t d;
    d = 25'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      d.width  = 4'($urandom_range(1, 8));
      d.lift   = 5'($urandom_range(0, 3));
      d.height = 5'($urandom_range(1, 12));
    end
    return d;
  endfunction

  // Number of codes from first_code on that hit the table.
  function automatic int font_span();
    int eff;
    eff = (cfg_count > MAX_GLYPHS) ? MAX_GLYPHS : int'(cfg_count);
    return (eff < 256 - int'(cfg_first)) ? eff : 256 - int'(cfg_first);
  endfunction

  function automatic logic [7:0] pick_code(input int span);
    if (span > 0 && $urandom_range(0, 3) != 0)
      return cfg_first + 8'($urandom_range(0, span - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] pick_col();
    if ($urandom_range(0, 9) < 7) return 4'($urandom_range(0, 9));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic push_item(input glyph_item_t r);
    queued_items.push_back(r);
    items_owed++;
    if (r.mode != MODE_SKIP) planned++;
  endtask

  task automatic push_desc(input int idx, input desc_t d);
    glyph_item_t r;
    r        = rand_item();
    r.mode   = MODE_DESC;
    r.addr   = 11'(idx);
    r.width  = d.width;
    r.lift   = d.lift;
    r.height = d.height;
    r.offset = d.offset;
    if (idx < MAX_GLYPHS) begin
      plan_desc[idx]    = d;
      plan_desc_ok[idx] = 1'b1;
    end
    push_item(r);
  endtask

  task automatic push_bmap(input int addr, input logic [7:0] data);
    glyph_item_t r;
    r      = rand_item();
    r.mode = MODE_BMAP;
    r.addr = 11'(addr);
    r.data = data;
    plan_byte_ok[addr % BITMAP_BYTES] = 1'b1;
    push_item(r);
  endtask

  task automatic push_noise();
    glyph_item_t r;
    r      = rand_item();
    r.mode = MODE_SKIP;
    push_item(r);
  endtask

  // Queue a draw, first filling in any descriptor or bitmap byte it would read unwritten.
  task automatic push_draw(input logic [7:0] code, input logic [3:0] col);
    glyph_item_t r;
    int          idx, baddr, bpos;
    if (resolve_glyph(code, idx)) begin
      if (!plan_desc_ok[idx]) push_desc(idx, pick_desc());
      for (int y = 0; y < row_count(); y++)
        if (ink_bit(plan_desc[idx], col, y, baddr, bpos) && !plan_byte_ok[baddr])
          push_bmap(baddr, 8'($urandom));
    end
    r      = rand_item();
    r.mode = MODE_DRAW;
    r.code = code;
    r.col  = col;
    push_item(r);
  endtask

  // Define a glyph with fresh bitmap bytes, then draw it column by column plus spacing.
  task automatic define_glyph(input int span);
    desc_t      d;
    int         idx, nbytes;
    logic [7:0] code;
    idx  = $urandom_range(0, span - 1);
    code = cfg_first + 8'(idx);
    d    = pick_desc();
    push_desc(idx, d);
    nbytes = (glyph_cols(d) * int'(d.height) + 7) / 8;
    if (nbytes > 6) nbytes = 6;
    for (int i = 0; i < nbytes; i++)
      push_bmap((int'(d.offset) + i) % BITMAP_BYTES, 8'($urandom));
    for (int c = 0; c <= glyph_cols(d); c++) push_draw(code, 4'(c));
  endtask

  task automatic random_items(input int budget);
    int stop, pick, span;
    stop = planned + budget;
    while (planned < stop) begin
      pick = $urandom_range(0, 99);
      span = font_span();
      if (pick < 40) push_draw(pick_code(span), pick_col());
      else if (pick < 58 && span > 0) define_glyph(span);
      else if (pick < 72)
        push_desc(($urandom_range(0, 9) < 7) ? $urandom_range(0, MAX_GLYPHS - 1)
                                               : $urandom_range(0, 2047), pick_desc());
      else if (pick < 92) push_bmap($urandom_range(0, BITMAP_BYTES - 1), 8'($urandom));
      else push_noise();
    end
  endtask

  // Wait until every item is taken and every pixel seen, then let the pipe run dry.
  task automatic settle();
    while (items_owed != 0 || pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FIRST_CODE:   cfg_first  = value[7:0];
      REG_GLYPH_COUNT:  cfg_count  = value[7:0];
      REG_MISSING_CODE: cfg_absent = value[7:0];
      REG_FONT_HEIGHT:  cfg_height = value[4:0];
      REG_INK_COLOR:    cfg_fg     = value[15:0];
      REG_PAPER_COLOR:  cfg_bg     = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_font_regs(input int first, input int count, input int absent,
                               input int height, input int fg, input int bg);
    settle();
    reg_write(REG_FIRST_CODE, 32'(first));
    reg_write(REG_GLYPH_COUNT, 32'(count));
    reg_write(REG_MISSING_CODE, 32'(absent));
    reg_write(REG_FONT_HEIGHT, 32'(height));
    reg_write(REG_INK_COLOR, 32'(fg));
    reg_write(REG_PAPER_COLOR, 32'(bg));
  endtask

  // ---------------------------------------------------------------------------------------
  // Item driver: present the next queued item whenever the slot is free
  // ---------------------------------------------------------------------------------------
  glyph_item_t cur_item;
  int          send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // Item taken at this edge: fold it into the expected font state.
      if (in_valid && !in_stall) begin
        apply_item(cur_item);
        items_owed--;
      end
      // Hold the payload while stalled; otherwise idle a while or advance.
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (queued_items.size() > 0) begin
          cur_item      = queued_items.pop_front();
          mode          <= cur_item.mode;
          char_code     <= cur_item.code;
          column        <= cur_item.col;
          table_address <= cur_item.addr;
          desc_width    <= cur_item.width;
          desc_lift     <= cur_item.lift;
          desc_height   <= cur_item.height;
          desc_offset   <= cur_item.offset;
          data_byte     <= cur_item.data;
          in_valid      <= 1'b1;
          send_gap      = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Alternate between stretches of random idling and stretches with none.
  int calm_left = 0;

  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(40, 250);
    end else begin
      calm_left--;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Pixel receiver: random stalls, plus one long hold-off so the block backs up into the
  // input channel while items keep coming
  // ---------------------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always @(posedge clk) begin
    if (!rst && !hold_done && pixels_seen >= 60) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_len();
      out_stall  <= 1'b0;
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= 40)
        $display("t=%0d ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Compare each pixel taken with the oldest expected one, field by field.
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        fails++;
        if (fails <= 40)
          $display("t=%0d ns: pixel with none expected, expected nothing, actual %0h/%0d/%0d/%0d",
                   $time, pixel_color, row, char_width, last_pixel);
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_color", want.color, pixel_color);
        check_field("row", 16'(want.row), 16'(row));
        check_field("char_width", 16'(want.width), 16'(char_width));
        check_field("last_pixel", 16'(want.last), 16'(last_pixel));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings leave the font empty and the absent code outside it: blank column.
    push_draw(8'h41, 4'd0);
    push_noise();
    // Descriptor writes past the table are dropped.
    push_desc(MAX_GLYPHS, pick_desc());
    push_desc(2047, pick_desc());
    push_bmap(BITMAP_BYTES - 1, 8'hA5);

    set_font_regs(32, 96, 63, 16, $urandom_range(0, 65535), $urandom_range(0, 65535));
    // Wide descriptor: width saturates, spacing column and columns past it stay blank.
    push_desc(0, '{4'd15, 5'd0, 5'd16, 11'd0});
    push_bmap(0, 8'hFF);
    push_bmap(1, 8'h00);
    push_draw(8'd32, 4'd0);
    push_draw(8'd32, 4'd7);
    push_draw(8'd32, 4'd8);
    push_draw(8'd32, 4'd15);
    // Last glyph of the font, its bits run off the end of the bitmap and wrap to byte 0.
    push_desc(95, '{4'd3, 5'd2, 5'd5, 11'd2047});
    push_draw(8'd127, 4'd2);
    // Absent glyph sits above every row; codes below and past the font fall back to it.
    push_desc(31, '{4'd2, 5'd16, 5'd4, 11'd40});
    push_draw(8'd63, 4'd1);
    push_draw(8'd31, 4'd0);
    push_draw(8'd128, 4'd0);
    // No ink rows, extreme lift and height, and a zero-width glyph.
    push_desc(1, '{4'd4, 5'd0, 5'd0, 11'd5});
    push_draw(8'd33, 4'd0);
    push_desc(2, '{4'd8, 5'd31, 5'd31, 11'd2047});
    push_draw(8'd34, 4'd3);
    push_desc(3, '{4'd1, 5'd0, 5'd31, 11'd100});
    push_draw(8'd35, 4'd0);
    push_desc(64, '{4'd0, 5'd0, 5'd8, 11'd10});
    push_draw(8'd96, 4'd0);
    random_items(95);

    // Glyph count past the table size, single-row font, inverted colors.
    set_font_regs(0, 255, 255, 1, 16'h0000, 16'hFFFF);
    random_items(60);
    // Zero rows: draws emit nothing.
    set_font_regs(255, 128, 0, 0, 16'hFFFF, 16'h0000);
    random_items(30);
    // One glyph at the top code, height beyond the row limit.
    set_font_regs(255, 1, 255, 31, $urandom_range(0, 65535), $urandom_range(0, 65535));
    random_items(40);
    // Empty font.
    set_font_regs(128, 0, 7, 8, $urandom_range(0, 65535), $urandom_range(0, 65535));
    random_items(30);
    repeat (3) begin
      set_font_regs($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(1, 31), $urandom_range(0, 65535), $urandom_range(0, 65535));
      random_items(48);
    end

    settle();
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Drop the run if it hangs.
  initial begin : watchdog
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
